// ===== rtl/ccu_pkg.sv =====
// ----------------------------------------------------------------------------
// ccu_pkg
// Shared types, constants and the channel-to-tower map for the channel
// unpacker.
// ----------------------------------------------------------------------------
package ccu_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0]  CHAN_COUNT    = 8'd144;
  localparam logic [7:0]  MAX_PACKET    = 8'd172;
  localparam logic [7:0]  LAST_LOW_PKT  = 8'd108;
  localparam logic [7:0]  LAST_ARM0_PKT = 8'd72;
  localparam logic [7:0]  FIRST_HI_PKT  = 8'd109;
  localparam logic [11:0] INVERT_MASK   = 12'hfff;

  localparam logic [1:0]  DET_LOW  = 2'd1;
  localparam logic [1:0]  DET_HIGH = 2'd2;

  // Tower index within the module for each front-end channel.
  localparam logic [7:0] TOWER_MAP [144] = '{
    8'd121, 8'd120, 8'd133, 8'd132, 8'd97,  8'd96,  8'd109, 8'd108,
    8'd73,  8'd72,  8'd85,  8'd84,
    8'd49,  8'd48,  8'd61,  8'd60,  8'd25,  8'd24,  8'd37,  8'd36,
    8'd1,   8'd0,   8'd13,  8'd12,
    8'd123, 8'd122, 8'd135, 8'd134, 8'd99,  8'd98,  8'd111, 8'd110,
    8'd75,  8'd74,  8'd87,  8'd86,
    8'd51,  8'd50,  8'd63,  8'd62,  8'd27,  8'd26,  8'd39,  8'd38,
    8'd3,   8'd2,   8'd15,  8'd14,
    8'd125, 8'd124, 8'd137, 8'd136, 8'd101, 8'd100, 8'd113, 8'd112,
    8'd77,  8'd76,  8'd89,  8'd88,
    8'd53,  8'd52,  8'd65,  8'd64,  8'd29,  8'd28,  8'd41,  8'd40,
    8'd5,   8'd4,   8'd17,  8'd16,
    8'd127, 8'd126, 8'd139, 8'd138, 8'd103, 8'd102, 8'd115, 8'd114,
    8'd79,  8'd78,  8'd91,  8'd90,
    8'd55,  8'd54,  8'd67,  8'd66,  8'd31,  8'd30,  8'd43,  8'd42,
    8'd7,   8'd6,   8'd19,  8'd18,
    8'd129, 8'd128, 8'd141, 8'd140, 8'd105, 8'd104, 8'd117, 8'd116,
    8'd81,  8'd80,  8'd93,  8'd92,
    8'd57,  8'd56,  8'd69,  8'd68,  8'd33,  8'd32,  8'd45,  8'd44,
    8'd9,   8'd8,   8'd21,  8'd20,
    8'd131, 8'd130, 8'd143, 8'd142, 8'd107, 8'd106, 8'd119, 8'd118,
    8'd83,  8'd82,  8'd95,  8'd94,
    8'd59,  8'd58,  8'd71,  8'd70,  8'd35,  8'd34,  8'd47,  8'd46,
    8'd11,  8'd10,  8'd23,  8'd22
  };

  // One classified hit, queued between front and back.
  typedef struct packed {
    logic [14:0] entry_id;
    logic [30:0] event_tag;
    logic        arm;
    logic [1:0]  sector;
    logic [5:0]  row_base;
    logic [6:0]  col_base;
    logic [7:0]  tower;
    logic [1:0]  det_class;
    logic [11:0] tdc_value;
    logic [11:0] adc_low_post;
    logic [11:0] adc_high_post;
    logic [11:0] adc_low_pre;
    logic [11:0] adc_high_pre;
    logic        module_mismatch;
  } ccu_item_t;

endpackage

// ===== rtl/ccu_front.sv =====
// ----------------------------------------------------------------------------
// ccu_front
// Accepts channels, drops empty and out-of-range ones, numbers the hits and
// splits the packet number into tower position bases.
// ----------------------------------------------------------------------------
module ccu_front import ccu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_event_start,
  input  logic [7:0]  in_packet_number,
  input  logic [7:0]  in_channel,
  input  logic [7:0]  in_module_number,
  input  logic [30:0] in_event_number,
  input  logic [11:0] in_raw_tdc,
  input  logic [11:0] in_raw_low_post,
  input  logic [11:0] in_raw_high_post,
  input  logic [11:0] in_raw_low_pre,
  input  logic [11:0] in_raw_high_pre,
  input  logic        fifo_full,
  output logic        push,
  output ccu_item_t   push_item
);

  logic [14:0] cnt_r, cnt_nxt, cnt_base, entry;
  logic        accept, pkt_ok, chan_ok, has_data, is_hit, low_pkt;
  logic [7:0]  tower;
  logic [6:0]  q_lo;
  logic [5:0]  q_hi;
  logic [12:0] q57;
  logic [2:0]  s18;
  logic [6:0]  r18_full;
  logic [4:0]  r18;
  logic [8:0]  r11;
  logic [1:0]  s6;
  logic [4:0]  r6_full;
  logic [2:0]  r6;
  logic [1:0]  sector_lo;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !in_stall;

  assign pkt_ok   = (in_packet_number != 8'd0) && (in_packet_number <= MAX_PACKET);
  assign chan_ok  = in_channel < CHAN_COUNT;
  assign has_data = |{in_raw_tdc, in_raw_low_post, in_raw_high_post,
                      in_raw_low_pre, in_raw_high_pre};
  assign is_hit   = pkt_ok && chan_ok && has_data;
  assign low_pkt  = in_packet_number <= LAST_LOW_PKT;

  assign cnt_base = in_event_start ? 15'd0 : cnt_r;
  assign entry    = cnt_base + 15'd1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = is_hit ? entry : cnt_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 15'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign tower = chan_ok ? TOWER_MAP[in_channel] : 8'd0;

  // Packets up to 108: groups of 18 modules per sector, 6 per row band.
  assign q_lo     = 7'(in_packet_number - 8'd1);
  assign q57      = 13'(q_lo) * 13'd57;
  assign s18      = q57[12:10];
  assign r18_full = q_lo - (7'(s18) * 7'd18);
  assign r18      = r18_full[4:0];
  assign r11      = 9'(r18) * 9'd11;
  assign s6       = r11[7:6];
  assign r6_full  = r18 - (5'(s6) * 5'd6);
  assign r6       = r6_full[2:0];
  assign sector_lo = (in_packet_number > LAST_ARM0_PKT) ? 2'(s18 - 3'd2) : s18[1:0];

  // Packets from 109: groups of 32 per sector, 8 per row band.
  assign q_hi = 6'(in_packet_number - FIRST_HI_PKT);

  always_comb begin
    push_item.entry_id        = entry;
    push_item.event_tag       = in_event_number;
    push_item.tower           = tower;
    push_item.tdc_value       = in_raw_tdc ^ INVERT_MASK;
    push_item.adc_low_post    = in_raw_low_post ^ INVERT_MASK;
    push_item.adc_high_post   = in_raw_high_post ^ INVERT_MASK;
    push_item.adc_low_pre     = in_raw_low_pre ^ INVERT_MASK;
    push_item.adc_high_pre    = in_raw_high_pre ^ INVERT_MASK;
    push_item.module_mismatch = in_module_number != in_packet_number;
    if (low_pkt) begin
      push_item.arm       = in_packet_number > LAST_ARM0_PKT;
      push_item.sector    = sector_lo;
      push_item.row_base  = 6'(s6) * 6'd12;
      push_item.col_base  = 7'(r6) * 7'd12;
      push_item.det_class = DET_LOW;
    end else begin
      push_item.arm       = 1'b1;
      push_item.sector    = {1'b0, q_hi[5]};
      push_item.row_base  = 6'(q_hi[4:3]) * 6'd12;
      push_item.col_base  = 7'(q_hi[2:0]) * 7'd12;
      push_item.det_class = DET_HIGH;
    end
  end

  assign push = accept && is_hit;

endmodule

// ===== rtl/ccu_fifo.sv =====
// ----------------------------------------------------------------------------
// ccu_fifo
// Short queue of classified hits between front and back.
// ----------------------------------------------------------------------------
module ccu_fifo import ccu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ccu_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output ccu_item_t head_item
);

  ccu_item_t            slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;

  assign full       = count_r == FIFO_CW'(FIFO_DEPTH);
  assign head_valid = count_r != '0;
  assign head_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("hit queue holds more than its depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("hit written into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("hit taken from an empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

// ===== rtl/ccu_back.sv =====
// ----------------------------------------------------------------------------
// ccu_back
// Completes the tower position, packs the software key and holds the result
// in the output register.
// ----------------------------------------------------------------------------
module ccu_back import ccu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  ccu_item_t   head_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_entry_id,
  output logic [30:0] out_event_tag,
  output logic [17:0] out_sw_key,
  output logic [1:0]  out_det_class,
  output logic [11:0] out_tdc_value,
  output logic [11:0] out_adc_low_post,
  output logic [11:0] out_adc_high_post,
  output logic [11:0] out_adc_low_pre,
  output logic [11:0] out_adc_high_pre,
  output logic        out_module_mismatch
);

  logic        valid_r, valid_nxt;
  logic [15:0] t171;
  logic [3:0]  t_div, t_mod;
  logic [7:0]  t_mod_full;
  logic [5:0]  row;
  logic [6:0]  col;
  logic [17:0] key;
  ccu_item_t   item_r;
  logic [17:0] key_r;

  assign pop = head_valid && (!valid_r || !out_stall);

  // tower / 12 and tower % 12
  assign t171       = 16'(head_item.tower) * 16'd171;
  assign t_div      = t171[14:11];
  assign t_mod_full = head_item.tower - (8'(t_div) * 8'd12);
  assign t_mod      = t_mod_full[3:0];
  assign row        = head_item.row_base + 6'(t_div);
  assign col        = head_item.col_base + 7'(t_mod);

  assign key = (head_item.arm ? 18'd100000 : 18'd0)
             + (18'(head_item.sector) * 18'd10000)
             + (18'(row) * 18'd100)
             + 18'(col);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head_item;
      key_r  <= key;
    end
  end

  assign out_valid           = valid_r;
  assign out_entry_id        = item_r.entry_id;
  assign out_event_tag       = item_r.event_tag;
  assign out_sw_key          = key_r;
  assign out_det_class       = item_r.det_class;
  assign out_tdc_value       = item_r.tdc_value;
  assign out_adc_low_post    = item_r.adc_low_post;
  assign out_adc_high_post   = item_r.adc_high_post;
  assign out_adc_low_pre     = item_r.adc_low_pre;
  assign out_adc_high_pre    = item_r.adc_high_pre;
  assign out_module_mismatch = item_r.module_mismatch;

endmodule

// ===== rtl/calorimeter_channel_unpacker.sv =====
// ----------------------------------------------------------------------------
// calorimeter_channel_unpacker
// Unpacks one front-end calorimeter channel per transaction into a tower hit.
//
// Input channel (in_*): one transaction per front-end channel, valid/stall.
//   Channels whose five raw words are all zero, or whose packet or channel
//   number is out of range, are consumed and give no result; in_event_start
//   restarts the entry numbering either way.
// Output channel (out_*): one transaction per hit, valid/stall, taken from
//   an output register.
// Throughput: one channel per cycle, sustained, as long as the receiver
//   takes results as fast.
// Path: a hit reaches out_* through the hit queue and then the output
//   register, held back by any hits queued ahead and by any stall.
// The front stage classifies, numbers and pre-maps each channel into a four
//   entry hit queue; the back stage finishes the tower mapping, packs the
//   software key and loads the output register.
// Receiver stall: the output register holds, the queue fills and in_stall
//   rises once four hits are waiting.
// Reset (rst_n low, synchronous): empties the queue, drops any held result
//   and clears the entry counter.
// ----------------------------------------------------------------------------
module calorimeter_channel_unpacker import ccu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_event_start,
  input  logic [7:0]  in_packet_number,
  input  logic [7:0]  in_channel,
  input  logic [7:0]  in_module_number,
  input  logic [30:0] in_event_number,
  input  logic [11:0] in_raw_tdc,
  input  logic [11:0] in_raw_low_post,
  input  logic [11:0] in_raw_high_post,
  input  logic [11:0] in_raw_low_pre,
  input  logic [11:0] in_raw_high_pre,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_entry_id,
  output logic [30:0] out_event_tag,
  output logic [17:0] out_sw_key,
  output logic [1:0]  out_det_class,
  output logic [11:0] out_tdc_value,
  output logic [11:0] out_adc_low_post,
  output logic [11:0] out_adc_high_post,
  output logic [11:0] out_adc_low_pre,
  output logic [11:0] out_adc_high_pre,
  output logic        out_module_mismatch
);

  // Front to queue: hits only, already numbered.
  logic      fifo_full, push, pop, head_valid;
  ccu_item_t push_item, head_item;

  ccu_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_event_start   (in_event_start),
    .in_packet_number (in_packet_number),
    .in_channel       (in_channel),
    .in_module_number (in_module_number),
    .in_event_number  (in_event_number),
    .in_raw_tdc       (in_raw_tdc),
    .in_raw_low_post  (in_raw_low_post),
    .in_raw_high_post (in_raw_high_post),
    .in_raw_low_pre   (in_raw_low_pre),
    .in_raw_high_pre  (in_raw_high_pre),
    .fifo_full        (fifo_full),
    .push             (push),
    .push_item        (push_item)
  );

  // Decouple the two sides so that a stalled receiver does not stop intake until the queue is full.
  ccu_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Back: finish mapping and drive the output register.
  ccu_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (head_valid),
    .head_item           (head_item),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_entry_id        (out_entry_id),
    .out_event_tag       (out_event_tag),
    .out_sw_key          (out_sw_key),
    .out_det_class       (out_det_class),
    .out_tdc_value       (out_tdc_value),
    .out_adc_low_post    (out_adc_low_post),
    .out_adc_high_post   (out_adc_high_post),
    .out_adc_low_pre     (out_adc_low_pre),
    .out_adc_high_pre    (out_adc_high_pre),
    .out_module_mismatch (out_module_mismatch)
  );

endmodule
